@@ rtl/core/chm_pkg.sv @@
// Package: shared types, constants and the request type codes for the hash map core.
package chm_pkg;

  localparam int NumBucketsDef  = 64;
  localparam int BucketSlotsDef = 4;
  localparam int CfgWidth       = 7;
  localparam int EntriesWidth   = 9;
  localparam int HashWidth      = 32;
  localparam int KeyWidth       = 64;
  localparam int ValueWidth     = 64;

  localparam logic [CfgWidth-1:0] BucketCountReset = 7'd64;

  localparam logic [1:0] REQ_GET     = 2'd0;
  localparam logic [1:0] REQ_PUT     = 2'd1;
  localparam logic [1:0] REQ_PUT_ABS = 2'd2;

  // A request after classification, as it travels from the front to the back.
  typedef struct packed {
    logic                  is_put;
    logic                  is_put_abs;
    logic [KeyWidth-1:0]   key;
    logic [HashWidth-1:0]  hash;
    logic [ValueWidth-1:0] value;
    logic [11:0]           bucket;
  } chm_req_t;

  typedef struct packed {
    logic                  found;
    logic [ValueWidth-1:0] result_value;
    logic                  status;
    logic [EntriesWidth-1:0] entries;
  } chm_rsp_t;

endpackage

@@ rtl/core/chm_front.sv @@
// Front end: takes requests, reduces the hash to a bucket index bit by bit.
module chm_front #(
  parameter int NUM_BUCKETS = chm_pkg::NumBucketsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     req_type,
  input  logic [chm_pkg::KeyWidth-1:0]   key,
  input  logic [chm_pkg::HashWidth-1:0]  hash,
  input  logic [chm_pkg::ValueWidth-1:0] value,
  input  logic [chm_pkg::CfgWidth-1:0]   bucket_count,
  output logic                           q_valid,
  input  logic                           q_ready,
  output chm_pkg::chm_req_t              q_req
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int RW = BW + 1;
  localparam int StepsPerCycle = 4;
  localparam int Cycles = (chm_pkg::HashWidth + StepsPerCycle - 1) / StepsPerCycle;
  localparam int CW = $clog2(Cycles + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOD  = 3'b010,
    ST_OUT  = 3'b100
  } fst_t;

  fst_t state;
  fst_t state_next;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem_next;
  logic [RW-1:0] div;
  logic [chm_pkg::HashWidth-1:0] sh;
  logic [chm_pkg::HashWidth-1:0] sh_next;
  chm_pkg::chm_req_t req;
  logic [RW:0] t;

  // Clamp the configured bucket count into 1..NUM_BUCKETS.
  logic [12:0] bc_use;
  always_comb begin
    bc_use = 13'(bucket_count);
    if (bucket_count == '0) bc_use = 13'd1;
    if (bc_use > 13'(NUM_BUCKETS)) bc_use = 13'(NUM_BUCKETS);
  end

  // Restoring remainder, StepsPerCycle hash bits per cycle, MSB first.
  always_comb begin
    rem_next = rem;
    sh_next  = sh;
    t        = '0;
    for (int i = 0; i < StepsPerCycle; i++) begin
      t = {rem_next, sh_next[chm_pkg::HashWidth-1]};
      sh_next = sh_next << 1;
      if (t >= {1'b0, div}) t = t - {1'b0, div};
      rem_next = t[RW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MOD;
      ST_MOD:  if (cnt == CW'(Cycles - 1)) state_next = ST_OUT;
      ST_OUT:  if (q_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MOD) cnt <= cnt + CW'(1);
      else cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req.is_put     <= (req_type == chm_pkg::REQ_PUT);
      req.is_put_abs <= (req_type == chm_pkg::REQ_PUT_ABS);
      req.key        <= key;
      req.hash       <= hash;
      req.value      <= value;
      req.bucket     <= '0;
      sh             <= hash;
      rem            <= '0;
      div            <= RW'(bc_use);
    end else if (state == ST_MOD) begin
      sh  <= sh_next;
      rem <= rem_next;
      if (cnt == CW'(Cycles - 1)) req.bucket <= 12'(rem_next);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign q_valid  = (state == ST_OUT);
  assign q_req    = req;

endmodule

@@ rtl/core/chm_fifo.sv @@
// Short request queue between the front end and the table engine.
module chm_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  chm_pkg::chm_req_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output chm_pkg::chm_req_t rd_data
);

  chm_pkg::chm_req_t mem [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

@@ rtl/core/chm_back.sv @@
// Table engine: scans a bucket slot by slot, updates it, and holds the result.
module chm_back #(
  parameter int NUM_BUCKETS  = chm_pkg::NumBucketsDef,
  parameter int BUCKET_SLOTS = chm_pkg::BucketSlotsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  chm_pkg::chm_req_t q_req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output chm_pkg::chm_rsp_t rsp
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int FW = $clog2(BUCKET_SLOTS + 1);
  localparam int Total = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int AW = (Total > 1) ? $clog2(Total) : 1;
  localparam int EW = chm_pkg::EntriesWidth;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FILL  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_DONE  = 6'b010000,
    ST_OUT   = 6'b100000
  } bst_t;

  bst_t state;
  chm_pkg::chm_req_t req;

  logic [chm_pkg::HashWidth-1:0]  mem_hash  [Total];
  logic [chm_pkg::KeyWidth-1:0]   mem_key   [Total];
  logic [chm_pkg::ValueWidth-1:0] mem_value [Total];
  logic [FW-1:0] fill_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] fill_vld;

  logic [chm_pkg::HashWidth-1:0]  rd_hash;
  logic [chm_pkg::KeyWidth-1:0]   rd_key;
  logic [chm_pkg::ValueWidth-1:0] rd_value;
  logic [FW-1:0] fill_rd;
  logic [FW-1:0] fill;
  logic [FW-1:0] idx;
  logic [EW-1:0] entry_count;

  logic wr_en;
  logic wr_full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] base;
  logic [BW-1:0] bkt;
  logic [BW-1:0] fill_addr;
  logic hit;
  logic ins_empty;

  assign bkt = req.bucket[BW-1:0];
  assign base = AW'(int'(bkt) * BUCKET_SLOTS);
  assign rd_addr = base + AW'(idx);
  assign hit = (rd_hash == req.hash) && (rd_key == req.key);
  // The fill count is fetched while the request is taken from the queue.
  assign fill_addr = (state == ST_IDLE) ? q_req.bucket[BW-1:0] : bkt;

  // For a put, an empty bucket goes straight to insertion from ST_DONE.
  assign ins_empty = (state == ST_DONE) && (fill == '0) && (req.is_put || req.is_put_abs);

  always_ff @(posedge clk) begin
    rd_hash  <= mem_hash[rd_addr];
    rd_key   <= mem_key[rd_addr];
    rd_value <= mem_value[rd_addr];
    fill_rd  <= fill_mem[fill_addr];
    if (wr_en) begin
      mem_value[wr_addr] <= req.value;
      if (wr_full) begin
        mem_hash[wr_addr] <= req.hash;
        mem_key[wr_addr]  <= req.key;
        fill_mem[bkt]     <= fill + FW'(1);
      end
    end
  end

  // Decide the write for the current slot compare, or for an insertion.
  always_comb begin
    wr_en   = 1'b0;
    wr_full = 1'b0;
    wr_addr = rd_addr;
    if (state == ST_CMP && hit && req.is_put) wr_en = 1'b1;
    if ((state == ST_CMP && !hit && idx + FW'(1) >= fill && fill < FW'(BUCKET_SLOTS) &&
         (req.is_put || req.is_put_abs)) || ins_empty) begin
      wr_en   = 1'b1;
      wr_full = 1'b1;
      wr_addr = base + AW'(fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_vld    <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (q_valid) begin
          req   <= q_req;
          idx   <= '0;
          state <= ST_FILL;
        end
        ST_FILL: begin
          if (fill_vld[bkt] && fill_rd != '0) begin
            fill  <= fill_rd;
            state <= ST_READ;
          end else begin
            fill  <= '0;
            state <= ST_DONE;
          end
        end
        ST_READ: state <= ST_CMP;
        ST_CMP: begin
          if (hit) begin
            rsp.found        <= 1'b1;
            rsp.result_value <= rd_value;
            rsp.status       <= 1'b0;
            rsp.entries      <= entry_count;
            state            <= ST_OUT;
            rsp_valid        <= 1'b1;
          end else if (idx + FW'(1) < fill) begin
            idx   <= idx + FW'(1);
            state <= ST_READ;
          end else begin
            rsp.found <= 1'b0;
            if (req.is_put || req.is_put_abs) begin
              if (fill >= FW'(BUCKET_SLOTS)) begin
                rsp.result_value <= '0;
                rsp.status       <= 1'b1;
                rsp.entries      <= entry_count;
              end else begin
                rsp.result_value <= req.is_put_abs ? req.value : '0;
                rsp.status       <= 1'b0;
                rsp.entries      <= entry_count + EW'(1);
                entry_count      <= entry_count + EW'(1);
              end
            end else begin
              rsp.result_value <= '0;
              rsp.status       <= 1'b0;
              rsp.entries      <= entry_count;
            end
            state     <= ST_OUT;
            rsp_valid <= 1'b1;
          end
        end
        ST_DONE: begin
          rsp.found <= 1'b0;
          rsp.status <= 1'b0;
          if (req.is_put || req.is_put_abs) begin
            rsp.result_value <= req.is_put_abs ? req.value : '0;
            rsp.entries      <= entry_count + EW'(1);
            entry_count      <= entry_count + EW'(1);
            fill_vld[bkt]    <= 1'b1;
          end else begin
            rsp.result_value <= '0;
            rsp.entries      <= entry_count;
          end
          state     <= ST_OUT;
          rsp_valid <= 1'b1;
        end
        ST_OUT: if (rsp_ready) begin
          rsp_valid <= 1'b0;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign q_ready = (state == ST_IDLE);

endmodule

@@ rtl/core/chained_hash_map_core.sv @@
// Top level: hash map core with a request front end, queue and table engine.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------
//   request   | push / full        | req_type, key, hash, value
//   result    | pop / empty        | found, result_value, status, entries
//   config    | cfg_valid/cfg_ready| cfg_data (bucket_count)
//
// The front end reduces the hash to a bucket, four bits per cycle, and takes a
// new request only after handing the last one to the queue. The engine reads the
// bucket's fill count, then reads and compares each slot in turn, or goes
// straight to its result for an empty bucket.
// The front can reduce the next request while the engine works on this one.
// Reset clears the per-bucket fill valid bits, so no clearing pass is needed.
// A result waiting for pop stalls the engine; the queue then fills and full rises.
module chained_hash_map_core #(
  parameter int NUM_BUCKETS  = chm_pkg::NumBucketsDef,
  parameter int BUCKET_SLOTS = chm_pkg::BucketSlotsDef
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       req_type,
  input  logic [chm_pkg::KeyWidth-1:0]     key,
  input  logic [chm_pkg::HashWidth-1:0]    hash,
  input  logic [chm_pkg::ValueWidth-1:0]   value,
  output logic                             empty,
  input  logic                             pop,
  output logic                             found,
  output logic [chm_pkg::ValueWidth-1:0]   result_value,
  output logic                             status,
  output logic [chm_pkg::EntriesWidth-1:0] entries,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [chm_pkg::CfgWidth-1:0]     cfg_data
);

  logic [chm_pkg::CfgWidth-1:0] bucket_count;
  logic in_ready;
  logic f_valid, f_ready, b_valid, b_ready, rsp_valid;
  chm_pkg::chm_req_t f_req, b_req;
  chm_pkg::chm_rsp_t rsp;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= chm_pkg::BucketCountReset;
    else if (cfg_valid) bucket_count <= cfg_data;
  end

  chm_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk, .rst, .in_valid(push), .in_ready, .req_type, .key, .hash, .value,
    .bucket_count, .q_valid(f_valid), .q_ready(f_ready), .q_req(f_req)
  );

  chm_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
  );

  chm_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_SLOTS(BUCKET_SLOTS)) u_back (
    .clk, .rst, .q_valid(b_valid), .q_ready(b_ready), .q_req(b_req),
    .rsp_valid, .rsp_ready(pop), .rsp
  );

  assign full         = ~in_ready;
  assign empty        = ~rsp_valid;
  assign found        = rsp.found;
  assign result_value = rsp.result_value;
  assign status       = rsp.status;
  assign entries      = rsp.entries;

endmodule

@@ dv/tb.sv @@
// Testbench for the chained hash map core: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SlotsPerBucket = 4;
  localparam int TableBuckets = 64;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic [1:0]  req;
    logic [63:0] key;
    logic [31:0] hash;
    logic [63:0] val;
  } map_req_t;

  typedef struct {
    logic        found;
    logic [63:0] rv;
    logic        status;
    logic [8:0]  entries;
  } map_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] req_type = '0;
  logic [63:0] key = '0;
  logic [31:0] hash = '0;
  logic [63:0] value = '0;
  logic cfg_valid = 1'b0;
  logic [6:0] cfg_data = '0;
  logic full, empty, found, status, cfg_ready;
  logic [63:0] result_value;
  logic [8:0] entries;

  chained_hash_map_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type), .key(key),
    .hash(hash), .value(value), .empty(empty), .pop(pop), .found(found),
    .result_value(result_value), .status(status), .entries(entries),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state of the table.
  logic [31:0] tbl_hash[TableBuckets*SlotsPerBucket];
  logic [63:0] tbl_key[TableBuckets*SlotsPerBucket];
  logic [63:0] tbl_val[TableBuckets*SlotsPerBucket];
  int unsigned tbl_fill[TableBuckets];
  int unsigned entry_total = 0;
  logic [6:0] bucket_setting = chm_pkg::BucketCountReset;

  map_req_t pending_reqs[$];
  map_rsp_t expected_rsps[$];
  map_req_t cur_req;
  bit sending = 0;
  bit no_idle = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int rsp_seen = 0;
  int errors = 0;
  int cycles = 0;

  map_req_t key_pool[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void predict_lookup(map_req_t r);
    int unsigned n, b, fill, base, at;
    bit hit;
    map_rsp_t e;
    n = (bucket_setting == 0) ? 1 : (bucket_setting > TableBuckets ? TableBuckets
                                                                     : bucket_setting);
    b = r.hash % n;
    fill = tbl_fill[b];
    base = b * SlotsPerBucket;
    hit = 0;
    at = 0;
    e = '{1'b0, 64'd0, 1'b0, 9'd0};
    for (int i = 0; i < fill; i++) begin
      if (!hit && tbl_hash[base+i] == r.hash && tbl_key[base+i] == r.key) begin
        hit = 1;
        at = base + i;
      end
    end
    if (hit) begin
      e.found = 1'b1;
      e.rv = tbl_val[at];
      if (r.req == chm_pkg::REQ_PUT) tbl_val[at] = r.val;
    end else if (r.req == chm_pkg::REQ_PUT || r.req == chm_pkg::REQ_PUT_ABS) begin
      if (fill >= SlotsPerBucket) begin
        e.status = 1'b1;
      end else begin
        tbl_hash[base+fill] = r.hash;
        tbl_key[base+fill] = r.key;
        tbl_val[base+fill] = r.val;
        tbl_fill[b] = fill + 1;
        entry_total++;
        if (r.req == chm_pkg::REQ_PUT_ABS) e.rv = r.val;
      end
    end
    e.entries = entry_total[8:0];
    expected_rsps.push_back(e);
  endfunction

  // Driver: one request in flight on the input side at a time.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_lookup(cur_req);
        sending = 0;
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          sending = 1;
          send_gap = no_idle ? 0 : $urandom_range(0, 4);
        end
      end
      push <= sending;
      req_type <= cur_req.req;
      key <= cur_req.key;
      hash <= cur_req.hash;
      value <= cur_req.val;
    end
  end

  // Monitor: checks each popped result and paces pop.
  always @(posedge clk) begin
    map_rsp_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          if (errors < 10) $display("ERROR: result with nothing expected");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (found !== e.found || result_value !== e.rv || status !== e.status ||
              entries !== e.entries) begin
            if (errors < 10)
              $display("ERROR: exp found=%0d value=%h status=%0d entries=%0d, got %0d %h %0d %0d",
                       e.found, e.rv, e.status, e.entries,
                       found, result_value, status, entries);
            errors++;
          end
        end
        // One long hold-off lets the block back up until full rises.
        if (rsp_seen == 300) hold_left = 500;
        else recv_gap = no_idle ? 0 : $urandom_range(0, 4);
        pop <= (hold_left == 0 && recv_gap == 0);
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic map_req_t make_req(logic [1:0] rq, logic [63:0] k, logic [31:0] h,
                                        logic [63:0] v);
    map_req_t r;
    r.req = rq;
    r.key = k;
    r.hash = h;
    r.val = v;
    return r;
  endfunction

  function automatic logic [1:0] pick_req();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 38) return chm_pkg::REQ_GET;
    if (p < 68) return chm_pkg::REQ_PUT;
    if (p < 94) return chm_pkg::REQ_PUT_ABS;
    return REQ_UNUSED;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic fill_random(int count);
    map_req_t p;
    int unsigned sel;
    key_pool.delete();
    for (int i = 0; i < 48; i++)
      key_pool.push_back(make_req(chm_pkg::REQ_GET, rand64(), $urandom, 64'd0));
    for (int i = 0; i < count; i++) begin
      p = key_pool[$urandom_range(0, key_pool.size() - 1)];
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        pending_reqs.push_back(make_req(pick_req(), p.key, p.hash, rand64()));
      end else if (sel < 93) begin
        pending_reqs.push_back(make_req(pick_req(), rand64(), $urandom, rand64()));
      end else if (sel < 97) begin
        // Known key under a hash that differs in one bit.
        p.hash[$urandom_range(0, 31)] ^= 1'b1;
        pending_reqs.push_back(make_req(pick_req(), p.key, p.hash, rand64()));
      end else begin
        // Known hash under a different key.
        pending_reqs.push_back(make_req(pick_req(), rand64(), p.hash, rand64()));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || sending || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [6:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    bucket_setting = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [6:0] settings[7] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd33, 7'd2};
    for (int i = 0; i < TableBuckets; i++) tbl_fill[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests with the reset bucket count.
    pending_reqs.push_back(make_req(chm_pkg::REQ_GET, '1, '1, '1));
    pending_reqs.push_back(make_req(chm_pkg::REQ_PUT, '1, '1, '1));
    pending_reqs.push_back(make_req(chm_pkg::REQ_PUT, '1, '1, 64'h1234));
    pending_reqs.push_back(make_req(chm_pkg::REQ_GET, '1, '1, '0));
    pending_reqs.push_back(make_req(chm_pkg::REQ_PUT_ABS, '1, '1, 64'h55));
    pending_reqs.push_back(make_req(chm_pkg::REQ_PUT_ABS, '0, '0, '0));
    pending_reqs.push_back(make_req(chm_pkg::REQ_PUT_ABS, 64'd9, '0, '1));
    pending_reqs.push_back(make_req(chm_pkg::REQ_GET, 64'd9, '0, '0));
    pending_reqs.push_back(make_req(REQ_UNUSED, 64'd9, '0, 64'd7));
    pending_reqs.push_back(make_req(REQ_UNUSED, 64'd77, 32'd77, 64'd7));
    pending_reqs.push_back(make_req(chm_pkg::REQ_GET, 64'd9, 32'd64, '0));
    // Five keys into one bucket: the last put and put-if-absent find it full.
    for (int i = 0; i < 5; i++)
      pending_reqs.push_back(make_req(chm_pkg::REQ_PUT, 64'd100 + i, 32'd5 + 64 * i,
                                      64'd200 + i));
    pending_reqs.push_back(make_req(chm_pkg::REQ_PUT_ABS, 64'd300, 32'd5, 64'd301));
    pending_reqs.push_back(make_req(chm_pkg::REQ_GET, 64'd103, 32'd197, '0));
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_bucket_count(settings[ph]);
      no_idle = (ph % 3 == 1);
      fill_random(230);
      wait_idle();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
